// ===== design/mbe_pkg.sv =====
// Package for the escape-time engine: widths, item structs, datapath commands,
// register indexes and saturation helpers.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    // Default geometry and fixed-point format
    localparam int IMAGE_WIDTH_DEF   = 1024;
    localparam int IMAGE_HEIGHT_DEF  = 1024;
    localparam int FRACTION_BITS_DEF = 28;

    // Field and datapath widths
    localparam int COORD_W  = 10;
    localparam int STEP_W   = 13;
    localparam int LIMIT_W  = 12;
    localparam int WORD_W   = 32;
    localparam int MUL_W    = WORD_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int WIDE_W   = PROD_W + 2;
    localparam int DIV_W    = COORD_W + WORD_W;
    localparam int SIZE_W   = 13;
    localparam int CFG_IDX_W = 3;

    // Constant divider: two digits, each with a partial dividend below size * 2^DIV_LO_W;
    // the reciprocal width covers image sizes of at least 16
    localparam int DIV_LO_W = DIV_W / 2;
    localparam int DIV_M_W  = SIZE_W + DIV_LO_W;
    localparam int RECIP_W  = DIV_M_W - 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    localparam logic signed [WIDE_W-1:0] Q_MAX_W = WIDE_W'(64'sd2147483647);
    localparam logic signed [WIDE_W-1:0] Q_MIN_W = -WIDE_W'(64'sd2147483648);

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ITER_LIMIT = 3'd0,
        CFG_ZOOM       = 3'd1,
        CFG_PAN_REAL   = 3'd2,
        CFG_PAN_IMAG   = 3'd3,
        CFG_REAL_LOW   = 3'd4,
        CFG_REAL_HIGH  = 3'd5,
        CFG_IMAG_LOW   = 3'd6,
        CFG_IMAG_HIGH  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [STEP_W-1:0]  step_count;
        logic               escaped;
    } out_item_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP_MUL,
        OP_DIV_START,
        OP_MAP_ADD,
        OP_ZOOM_MUL,
        OP_MAP_PAN,
        OP_SQ_R,
        OP_SQ_I,
        OP_CROSS,
        OP_UPDATE,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;   // 0: real axis from column, 1: imaginary axis from row
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic escape;
        logic limit_hit;
    } dp_status_t;

    // Sign-extend a word into the wide domain
    function automatic logic signed [WIDE_W-1:0] ext_word(input logic signed [WORD_W-1:0] v);
        return {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    // Sign-extend a product into the wide domain
    function automatic logic signed [WIDE_W-1:0] ext_prod(input logic signed [PROD_W-1:0] v);
        return {{(WIDE_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    // Clamp a wide value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > Q_MAX_W) begin
            r = Q_MAX_W[WORD_W-1:0];
        end else if (v < Q_MIN_W) begin
            r = Q_MIN_W[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mandelbrot_escape_time.sv =====
// Mapping of each axis runs through the two-digit constant divider.
// Each iteration runs on the single shared 33x33 multiplier.
// One item at a time; the next item is accepted the cycle after a result is
// loaded, while that result still waits.
// Reset (rst_n, asynchronous) loads the register defaults and idles the block.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time
    import mbe_pkg::*;
#(
    parameter int IMAGE_WIDTH   = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT  = IMAGE_HEIGHT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mbe_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mbe_datapath #(
        .IMAGE_WIDTH   (IMAGE_WIDTH),
        .IMAGE_HEIGHT  (IMAGE_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .result    (out_data)
    );

endmodule

`default_nettype wire

// ===== design/mbe_divider.sv =====
// Division by the image size for the coordinate mapping: two digits, each estimated by
// a reciprocal multiply and fixed by one compare and subtract. Depends on mbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbe_divider
    import mbe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_W-1:0]   dividend,
    input  wire logic [SIZE_W-1:0]  divisor,
    input  wire logic [RECIP_W-1:0] recip,
    output logic                    done,
    output logic [DIV_W-1:0]        quotient,
    output logic                    rem_nonzero
);

    localparam int HI_W     = DIV_W - DIV_LO_W;
    localparam int PROD_R_W = DIV_M_W + RECIP_W;
    localparam int QD_W     = RECIP_W + SIZE_W;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_EST,
        P_FIX
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic                last_reg, last_next;      // working on the low digit
    logic                done_reg, done_next;
    logic [SIZE_W-1:0]   den_reg, den_next;
    logic [RECIP_W-1:0]  rec_reg, rec_next;
    logic [DIV_LO_W-1:0] low_reg, low_next;
    logic [DIV_M_W-1:0]  part_reg, part_next;
    logic [RECIP_W-1:0]  est_reg, est_next;
    logic [DIV_M_W-1:0]  qd_reg, qd_next;
    logic [HI_W-1:0]     q_hi_reg, q_hi_next;
    logic [DIV_W-1:0]    quo_reg, quo_next;
    logic                rem_nz_reg, rem_nz_next;

    logic [PROD_R_W-1:0] prod_full;
    logic [QD_W-1:0]     qd_full;
    logic [DIV_M_W-1:0]  den_ext, diff, rem_fix;
    logic                fits;
    logic [RECIP_W-1:0]  digit;

    // Estimate one digit low by at most one, multiply back and correct once
    always_comb begin
        prod_full = part_reg * rec_reg;
        qd_full   = est_reg * den_reg;
        den_ext   = {{(DIV_M_W-SIZE_W){1'b0}}, den_reg};
        diff      = part_reg - qd_reg;
        fits      = diff >= den_ext;
        rem_fix   = fits ? diff - den_ext : diff;
        digit     = est_reg + {{(RECIP_W-1){1'b0}}, fits};
    end

    // Advance through the high digit, then the low digit
    always_comb begin
        phase_next  = phase_reg;
        last_next   = last_reg;
        done_next   = 1'b0;
        den_next    = den_reg;
        rec_next    = rec_reg;
        low_next    = low_reg;
        part_next   = part_reg;
        est_next    = est_reg;
        qd_next     = qd_reg;
        q_hi_next   = q_hi_reg;
        quo_next    = quo_reg;
        rem_nz_next = rem_nz_reg;
        if (start) begin
            den_next   = divisor;
            rec_next   = recip;
            low_next   = dividend[DIV_LO_W-1:0];
            part_next  = {{(DIV_M_W-HI_W){1'b0}}, dividend[DIV_W-1:DIV_LO_W]};
            last_next  = 1'b0;
            phase_next = P_MUL;
        end else begin
            case (phase_reg)
                P_MUL: begin
                    est_next   = prod_full[PROD_R_W-1:DIV_M_W];
                    phase_next = P_EST;
                end
                P_EST: begin
                    qd_next    = qd_full[DIV_M_W-1:0];
                    phase_next = P_FIX;
                end
                P_FIX: begin
                    if (!last_reg) begin
                        q_hi_next  = digit[HI_W-1:0];
                        part_next  = {rem_fix[SIZE_W-1:0], low_reg};
                        last_next  = 1'b1;
                        phase_next = P_MUL;
                    end else begin
                        quo_next    = {q_hi_reg, digit[DIV_LO_W-1:0]};
                        rem_nz_next = |rem_fix;
                        done_next   = 1'b1;
                        phase_next  = P_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg  <= P_IDLE;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
            den_reg    <= '0;
            rec_reg    <= '0;
            low_reg    <= '0;
            part_reg   <= '0;
            est_reg    <= '0;
            qd_reg     <= '0;
            q_hi_reg   <= '0;
            quo_reg    <= '0;
            rem_nz_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
            den_reg    <= den_next;
            rec_reg    <= rec_next;
            low_reg    <= low_next;
            part_reg   <= part_next;
            est_reg    <= est_next;
            qd_reg     <= qd_next;
            q_hi_reg   <= q_hi_next;
            quo_reg    <= quo_next;
            rem_nz_reg <= rem_nz_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = rem_nz_reg;

endmodule

`default_nettype wire

// ===== design/mbe_datapath.sv =====
// Datapath: configuration registers, shared 33x33 multiplier, coordinate
// mapping, z = z^2 + c update, escape test and result register.
// Depends on mbe_pkg and mbe_divider.
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int IMAGE_WIDTH   = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT  = IMAGE_HEIGHT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire in_item_t             in_data,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output out_item_t                 result
);

    // Width of a floor-shifted square of a word
    localparam int SQ_W = 64 - FRACTION_BITS;

    localparam logic signed [WIDE_W-1:0] ONE_W   = $signed(WIDE_W'(1)) <<< FRACTION_BITS;
    localparam logic signed [WIDE_W-1:0] FIVE_W  = $signed(WIDE_W'(5)) <<< FRACTION_BITS;
    localparam logic signed [WIDE_W-1:0] TWO_W   = $signed(WIDE_W'(2)) <<< FRACTION_BITS;
    localparam logic signed [WIDE_W-1:0] ONE5_W  = $signed(WIDE_W'(3)) <<< (FRACTION_BITS - 1);

    localparam logic signed [WORD_W-1:0] RST_ZOOM      = sat_word(ONE_W);
    localparam logic signed [WORD_W-1:0] RST_REAL_LOW  = sat_word(-TWO_W);
    localparam logic signed [WORD_W-1:0] RST_REAL_HIGH = sat_word(ONE_W);
    localparam logic signed [WORD_W-1:0] RST_IMAG_LOW  = sat_word(-ONE5_W);
    localparam logic signed [WORD_W-1:0] RST_IMAG_HIGH = sat_word(ONE5_W);

    localparam logic [SIZE_W-1:0] WIDTH_DIV  = SIZE_W'(IMAGE_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_DIV = SIZE_W'(IMAGE_HEIGHT);

    // Reciprocals of the image sizes for the divider
    localparam logic [RECIP_W-1:0] WIDTH_RECIP  =
        RECIP_W'((64'd1 << DIV_M_W) / 64'(IMAGE_WIDTH));
    localparam logic [RECIP_W-1:0] HEIGHT_RECIP =
        RECIP_W'((64'd1 << DIV_M_W) / 64'(IMAGE_HEIGHT));

    // Configuration registers
    logic [LIMIT_W-1:0]       limit_reg;
    logic signed [WORD_W-1:0] zoom_reg, pan_real_reg, pan_imag_reg;
    logic signed [WORD_W-1:0] real_low_reg, real_high_reg, imag_low_reg, imag_high_reg;

    // Working registers
    logic [COORD_W-1:0]       col_reg, row_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic signed [WORD_W-1:0] t_reg, cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [SQ_W-1:0]   zr2_reg, zi2_reg;
    logic [STEP_W-1:0]        steps_reg;
    out_item_t                result_reg;

    // Shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [COORD_W-1:0]       coord;
    logic signed [WORD_W-1:0] low_sel, high_sel, pan_sel;
    logic signed [MUL_W-1:0]  span;
    logic signed [PROD_W-1:0] prod_sh, cross_sh;
    logic [PROD_W-1:0]        prod_abs;
    logic signed [WIDE_W-1:0] zr2_w, zi2_w, sq_sum;
    logic                     escape;

    logic [DIV_W-1:0]         div_quo;
    logic                     div_nz, div_done;
    logic [DIV_W:0]           q_mag;
    logic signed [WIDE_W-1:0] q_w;
    logic signed [WORD_W-1:0] t_next, c_next, zr_next, zi_next;

    // Select the axis being mapped
    always_comb begin
        coord    = cmd.axis ? row_reg : col_reg;
        low_sel  = cmd.axis ? imag_low_reg : real_low_reg;
        high_sel = cmd.axis ? imag_high_reg : real_high_reg;
        pan_sel  = cmd.axis ? pan_imag_reg : pan_real_reg;
        span     = {high_sel[WORD_W-1], high_sel} - {low_sel[WORD_W-1], low_sel};
    end

    // Route multiplier operands
    always_comb begin
        case (cmd.op)
            OP_MAP_MUL: begin
                mul_a = {{(MUL_W-COORD_W){1'b0}}, coord};
                mul_b = span;
            end
            OP_ZOOM_MUL: begin
                mul_a = {t_reg[WORD_W-1], t_reg};
                mul_b = {zoom_reg[WORD_W-1], zoom_reg};
            end
            OP_SQ_R: begin
                mul_a = {zr_reg[WORD_W-1], zr_reg};
                mul_b = {zr_reg[WORD_W-1], zr_reg};
            end
            OP_SQ_I: begin
                mul_a = {zi_reg[WORD_W-1], zi_reg};
                mul_b = {zi_reg[WORD_W-1], zi_reg};
            end
            OP_CROSS: begin
                mul_a = {zr_reg[WORD_W-1], zr_reg};
                mul_b = {zi_reg[WORD_W-1], zi_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Floor shifts of the registered product; magnitude for the divider
    always_comb begin
        prod_sh  = prod_reg >>> FRACTION_BITS;
        cross_sh = prod_reg >>> (FRACTION_BITS - 1);
        prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : prod_reg;
    end

    mbe_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.op == OP_DIV_START),
        .dividend    (prod_abs[DIV_W-1:0]),
        .divisor     (cmd.axis ? HEIGHT_DIV : WIDTH_DIV),
        .recip       (cmd.axis ? HEIGHT_RECIP : WIDTH_RECIP),
        .done        (div_done),
        .quotient    (div_quo),
        .rem_nonzero (div_nz)
    );

    // Floor quotient (round a negative one away from zero), add the low bound,
    // then zoom and pan
    always_comb begin
        q_mag  = {1'b0, div_quo} + {{DIV_W{1'b0}}, neg_reg & div_nz};
        q_w    = {{(WIDE_W-DIV_W-1){1'b0}}, q_mag};
        q_w    = neg_reg ? -q_w : q_w;
        t_next = sat_word(ext_word(sat_word(q_w)) + ext_word(low_sel));
        c_next = sat_word(ext_word(sat_word(ext_prod(prod_sh))) + ext_word(pan_sel));
    end

    // Escape test and next z
    always_comb begin
        zr2_w   = {{(WIDE_W-SQ_W){zr2_reg[SQ_W-1]}}, zr2_reg};
        zi2_w   = {{(WIDE_W-SQ_W){zi2_reg[SQ_W-1]}}, zi2_reg};
        sq_sum  = zr2_w + zi2_w;
        escape  = sq_sum >= FIVE_W;
        zr_next = sat_word(ext_word(sat_word(zr2_w - zi2_w)) + ext_word(cr_reg));
        zi_next = sat_word(ext_word(sat_word(ext_prod(cross_sh))) + ext_word(ci_reg));
    end

    assign status.div_done  = div_done;
    assign status.escape    = escape;
    assign status.limit_hit = steps_reg >= {limit_reg, 1'b0};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_reg     <= LIMIT_RESET;
            zoom_reg      <= RST_ZOOM;
            pan_real_reg  <= '0;
            pan_imag_reg  <= '0;
            real_low_reg  <= RST_REAL_LOW;
            real_high_reg <= RST_REAL_HIGH;
            imag_low_reg  <= RST_IMAG_LOW;
            imag_high_reg <= RST_IMAG_HIGH;
        end else if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                CFG_ITER_LIMIT: limit_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_ZOOM:       zoom_reg      <= cfg_data;
                CFG_PAN_REAL:   pan_real_reg  <= cfg_data;
                CFG_PAN_IMAG:   pan_imag_reg  <= cfg_data;
                CFG_REAL_LOW:   real_low_reg  <= cfg_data;
                CFG_REAL_HIGH:  real_high_reg <= cfg_data;
                CFG_IMAG_LOW:   imag_low_reg  <= cfg_data;
                CFG_IMAG_HIGH:  imag_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Working registers, advanced by the controller's command
    always_ff @(posedge clk) begin
        case (cmd.op)
            OP_LOAD: begin
                col_reg   <= in_data.pixel_col;
                row_reg   <= in_data.pixel_row;
                zr_reg    <= '0;
                zi_reg    <= '0;
                steps_reg <= '0;
            end
            OP_MAP_MUL, OP_ZOOM_MUL, OP_SQ_R: begin
                prod_reg <= mul_p;
            end
            OP_DIV_START: begin
                neg_reg <= prod_reg[PROD_W-1];
            end
            OP_MAP_ADD: begin
                t_reg <= t_next;
            end
            OP_MAP_PAN: begin
                if (cmd.axis) begin
                    ci_reg <= c_next;
                end else begin
                    cr_reg <= c_next;
                end
            end
            OP_SQ_I: begin
                zr2_reg  <= prod_sh[SQ_W-1:0];
                prod_reg <= mul_p;
            end
            OP_CROSS: begin
                zi2_reg  <= prod_sh[SQ_W-1:0];
                prod_reg <= mul_p;
            end
            OP_UPDATE: begin
                zr_reg    <= zr_next;
                zi_reg    <= zi_next;
                steps_reg <= steps_reg + STEP_W'(1);
            end
            OP_FINISH: begin
                result_reg.out_col    <= col_reg;
                result_reg.out_row    <= row_reg;
                result_reg.step_count <= steps_reg;
                result_reg.escaped    <= escape;
            end
            default: ;
        endcase
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/mbe_controller.sv =====
// Controller: sequences mapping, divider wait and the iteration,
// and owns the input and output handshakes. Depends on mbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbe_controller
    import mbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_MAP_ADD,
        S_ZOOM_MUL,
        S_MAP_PAN,
        S_SQ_R,
        S_SQ_I,
        S_CROSS,
        S_CHECK,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   out_valid_reg, out_valid_next;
    dp_op_t op;

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        op             = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op         = OP_LOAD;
                    axis_next  = 1'b0;
                    state_next = S_MAP_MUL;
                end
            end
            S_MAP_MUL: begin
                op         = OP_MAP_MUL;
                state_next = S_DIV_START;
            end
            S_DIV_START: begin
                op         = OP_DIV_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = S_MAP_ADD;
                end
            end
            S_MAP_ADD: begin
                op         = OP_MAP_ADD;
                state_next = S_ZOOM_MUL;
            end
            S_ZOOM_MUL: begin
                op         = OP_ZOOM_MUL;
                state_next = S_MAP_PAN;
            end
            S_MAP_PAN: begin
                op = OP_MAP_PAN;
                if (axis_reg) begin
                    state_next = S_SQ_R;
                end else begin
                    axis_next  = 1'b1;
                    state_next = S_MAP_MUL;
                end
            end
            S_SQ_R: begin
                op         = OP_SQ_R;
                state_next = S_SQ_I;
            end
            S_SQ_I: begin
                op         = OP_SQ_I;
                state_next = S_CROSS;
            end
            S_CROSS: begin
                op         = OP_CROSS;
                state_next = S_CHECK;
            end
            // Stop on escape first, then on the step limit
            S_CHECK: begin
                if (status.escape || status.limit_hit) begin
                    state_next = S_FLUSH;
                end else begin
                    op         = OP_UPDATE;
                    state_next = S_SQ_R;
                end
            end
            // Hold until the output register is free
            S_FLUSH: begin
                if (!out_valid_reg || out_ready) begin
                    op             = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.op    = op;
    assign cmd.axis  = axis_reg;

endmodule

`default_nettype wire

// ===== design/mbe_checker.sv =====
// Port-level checker for the escape-time engine, bound to the top level.
// Depends on mbe_pkg and on the port list of mandelbrot_escape_time.
`timescale 1ns / 1ps
`default_nettype none

module mbe_checker
    import mbe_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // An accepted item leaves the engine busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // A new result appears together with the engine going idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded while the engine is still busy");

    // A point that did not escape stopped at the limit, an even step count
    a_limit_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.escaped |-> !out_data.step_count[0])
        else $error("non-escaped result with odd step count");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

`default_nettype wire
